FILE: hw/rtl/sbip_pkg.sv
// Shared types and constants of the shader bytecode instruction parser.
package sbip_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_INCOUNT,
      PH_REL,
      PH_TABLE,
      PH_OFFSET,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ERR_OK,
      ERR_TRUNCATED,
      ERR_COMPONENTS,
      ERR_OPCODE,
      ERR_INPUT_COUNT,
      ERR_RELATIVE,
      ERR_TABLE
   } err_type;

   typedef enum logic [2:0] {
      TBL_IMM,
      TBL_CONST,
      TBL_OUT_CONST,
      TBL_OUT_BOOL,
      TBL_OUT_INT,
      TBL_TEMP
   } tbl_type;

   // Table codes as they appear in the word stream.
   localparam logic [31:0] CODE_IMM       = 32'd1;
   localparam logic [31:0] CODE_CONST     = 32'd2;
   localparam logic [31:0] CODE_OUT_CONST = 32'd4;
   localparam logic [31:0] CODE_OUT_BOOL  = 32'd5;
   localparam logic [31:0] CODE_OUT_INT   = 32'd6;
   localparam logic [31:0] CODE_TEMP      = 32'd7;

   localparam logic [10:0] OPCODE_NOP = 11'h000;
   localparam logic [10:0] OPCODE_MOV = 11'h100;
   localparam logic [15:0] COUNT_MAX  = 16'hffff;

   typedef struct packed {
      logic [31:0] word;
      logic        start_req;
      logic [15:0] words_following;
   } req_type;

   typedef struct packed {
      err_type     error_code;
      logic        operation;
      logic        scalar_first;
      logic [2:0]  comp_count;
      logic        has_input;
      logic [2:0]  input_table;
      logic [31:0] input_offset;
      logic [2:0]  output_table;
      logic [31:0] output_offset;
      logic        last_instruction;
   } rsp_type;

   typedef struct packed {
      logic    ok;
      tbl_type tbl;
   } tbl_dec_type;

   function automatic tbl_dec_type decode_table(input logic [31:0] code);
      tbl_dec_type d;
      d.ok  = 1'b1;
      d.tbl = TBL_IMM;
      case (code)
         CODE_IMM:       d.tbl = TBL_IMM;
         CODE_CONST:     d.tbl = TBL_CONST;
         CODE_OUT_CONST: d.tbl = TBL_OUT_CONST;
         CODE_OUT_BOOL:  d.tbl = TBL_OUT_BOOL;
         CODE_OUT_INT:   d.tbl = TBL_OUT_INT;
         CODE_TEMP:      d.tbl = TBL_TEMP;
         default:        d.ok  = 1'b0;
      endcase
      return d;
   endfunction

endpackage

FILE: hw/rtl/sbip_in_reg.sv
// Input register stage of the shader bytecode instruction parser.
module sbip_in_reg
   import sbip_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_word,
   input  logic        req_start_req,
   input  logic [15:0] req_words_following,
   input  logic        advance,
   output logic        item_valid,
   output req_type     item
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   // Take a new transaction when the stage is empty or drains this cycle.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in                = 1'b1;
         item_in.word            = req_word;
         item_in.start_req       = req_start_req;
         item_in.words_following = req_words_following;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: hw/rtl/sbip_parser.sv
// Parser state machine: consumes one word per step and forms at most one result.
module sbip_parser
   import sbip_pkg::*;
#(
   parameter int MAX_SECTION_WORDS = 65535
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output logic    res_valid,
   output rsp_type res
);

   localparam logic [15:0] MaxWords = 16'(MAX_SECTION_WORDS);

   phase_type   phase_ff, phase_in;
   logic [15:0] words_left_ff, words_left_in;
   logic [15:0] instr_left_ff, instr_left_in;
   logic        exp_in_ff, exp_in_in;
   logic        opnd_idx_ff, opnd_idx_in;
   logic        hdr_op_ff, hdr_op_in;
   logic        hdr_scalar_ff, hdr_scalar_in;
   logic [2:0]  hdr_ncomp_ff, hdr_ncomp_in;
   logic        hdr_unknown_ff, hdr_unknown_in;
   tbl_type     pend_tbl_ff, pend_tbl_in;
   tbl_type     in_tbl_ff, in_tbl_in;
   logic [31:0] in_off_ff, in_off_in;

   logic [31:0] w;
   logic        ncomp_ok;
   logic [10:0] opcode;
   tbl_dec_type tdec;
   logic [31:0] off;
   logic [15:0] wl_dec;
   logic [15:0] il_dec;
   logic [15:0] start_words;
   logic [15:0] start_instr;

   assign w        = item.word;
   assign ncomp_ok = (w[15:3] == 13'd0) && (w[2:0] != 3'd0) && (w[2:0] <= 3'd4);
   assign opcode   = w[30:20];
   assign tdec     = decode_table(w);
   assign off      = (pend_tbl_ff == TBL_OUT_BOOL) ? {2'b00, w[31:2]} : w;
   assign wl_dec   = words_left_ff - 16'd1;
   assign il_dec   = instr_left_ff - 16'd1;
   assign start_words = (item.words_following > MaxWords) ? MaxWords
                                                          : item.words_following;
   assign start_instr = (w > {16'd0, COUNT_MAX}) ? COUNT_MAX : w[15:0];

   // Next state.
   always_comb begin
      phase_in       = phase_ff;
      words_left_in  = words_left_ff;
      instr_left_in  = instr_left_ff;
      exp_in_in      = exp_in_ff;
      opnd_idx_in    = opnd_idx_ff;
      hdr_op_in      = hdr_op_ff;
      hdr_scalar_in  = hdr_scalar_ff;
      hdr_ncomp_in   = hdr_ncomp_ff;
      hdr_unknown_in = hdr_unknown_ff;
      pend_tbl_in    = pend_tbl_ff;
      in_tbl_in      = in_tbl_ff;
      in_off_in      = in_off_ff;
      if (step && item.start_req) begin
         words_left_in  = start_words;
         instr_left_in  = start_instr;
         exp_in_in      = 1'b0;
         opnd_idx_in    = 1'b0;
         hdr_op_in      = 1'b0;
         hdr_scalar_in  = 1'b0;
         hdr_ncomp_in   = 3'd0;
         hdr_unknown_in = 1'b0;
         pend_tbl_in    = TBL_IMM;
         in_tbl_in      = TBL_IMM;
         in_off_in      = 32'd0;
         phase_in       = (start_instr != 16'd0) ? PH_HEADER : PH_DONE;
      end else if (step) begin
         case (phase_ff)
            PH_HEADER: begin
               if (words_left_ff < 16'd2) begin
                  phase_in = PH_DONE;
               end else begin
                  words_left_in = wl_dec;
                  if (!ncomp_ok) begin
                     phase_in = PH_DONE;
                  end else begin
                     hdr_ncomp_in   = w[2:0];
                     hdr_scalar_in  = w[31];
                     hdr_op_in      = (opcode == OPCODE_MOV);
                     hdr_unknown_in = (opcode != OPCODE_MOV) && (opcode != OPCODE_NOP);
                     phase_in       = PH_INCOUNT;
                  end
               end
            end
            PH_INCOUNT: begin
               words_left_in = wl_dec;
               exp_in_in     = hdr_op_ff;
               if (hdr_unknown_ff || (w != {31'd0, hdr_op_ff})) begin
                  phase_in = PH_DONE;
               end else begin
                  opnd_idx_in = !hdr_op_ff;
                  in_tbl_in   = TBL_IMM;
                  in_off_in   = 32'd0;
                  phase_in    = PH_REL;
               end
            end
            PH_REL: begin
               if (words_left_ff < 16'd3) begin
                  phase_in = PH_DONE;
               end else begin
                  words_left_in = wl_dec;
                  phase_in      = (w != 32'd0) ? PH_DONE : PH_TABLE;
               end
            end
            PH_TABLE: begin
               words_left_in = wl_dec;
               if (!tdec.ok) begin
                  phase_in = PH_DONE;
               end else begin
                  pend_tbl_in = tdec.tbl;
                  phase_in    = PH_OFFSET;
               end
            end
            PH_OFFSET: begin
               words_left_in = wl_dec;
               if (!opnd_idx_ff) begin
                  in_tbl_in   = pend_tbl_ff;
                  in_off_in   = off;
                  opnd_idx_in = 1'b1;
                  phase_in    = PH_REL;
               end else begin
                  instr_left_in = il_dec;
                  phase_in      = (il_dec != 16'd0) ? PH_HEADER : PH_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Result.
   always_comb begin
      res_valid = 1'b0;
      res       = '0;
      if (step && !item.start_req) begin
         case (phase_ff)
            PH_HEADER: begin
               if (words_left_ff < 16'd2) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_TRUNCATED;
               end else if (!ncomp_ok) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_COMPONENTS;
               end
            end
            PH_INCOUNT: begin
               if (hdr_unknown_ff) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_OPCODE;
               end else if (w != {31'd0, hdr_op_ff}) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_INPUT_COUNT;
               end
            end
            PH_REL: begin
               if (words_left_ff < 16'd3) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_TRUNCATED;
               end else if (w != 32'd0) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_RELATIVE;
               end
            end
            PH_TABLE: begin
               if (!tdec.ok) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_TABLE;
               end
            end
            PH_OFFSET: begin
               if (opnd_idx_ff) begin
                  res_valid            = 1'b1;
                  res.error_code       = ERR_OK;
                  res.operation        = hdr_op_ff;
                  res.scalar_first     = hdr_scalar_ff;
                  res.comp_count       = hdr_ncomp_ff;
                  res.has_input        = exp_in_ff;
                  res.input_table      = exp_in_ff ? in_tbl_ff : TBL_IMM;
                  res.input_offset     = exp_in_ff ? in_off_ff : 32'd0;
                  res.output_table     = pend_tbl_ff;
                  res.output_offset    = off;
                  res.last_instruction = (il_dec == 16'd0);
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         words_left_ff  <= 16'd0;
         instr_left_ff  <= 16'd0;
         exp_in_ff      <= 1'b0;
         opnd_idx_ff    <= 1'b0;
         hdr_op_ff      <= 1'b0;
         hdr_scalar_ff  <= 1'b0;
         hdr_ncomp_ff   <= 3'd0;
         hdr_unknown_ff <= 1'b0;
         pend_tbl_ff    <= TBL_IMM;
         in_tbl_ff      <= TBL_IMM;
         in_off_ff      <= 32'd0;
      end else begin
         phase_ff       <= phase_in;
         words_left_ff  <= words_left_in;
         instr_left_ff  <= instr_left_in;
         exp_in_ff      <= exp_in_in;
         opnd_idx_ff    <= opnd_idx_in;
         hdr_op_ff      <= hdr_op_in;
         hdr_scalar_ff  <= hdr_scalar_in;
         hdr_ncomp_ff   <= hdr_ncomp_in;
         hdr_unknown_ff <= hdr_unknown_in;
         pend_tbl_ff    <= pend_tbl_in;
         in_tbl_ff      <= in_tbl_in;
         in_off_ff      <= in_off_in;
      end
   end

endmodule

FILE: hw/rtl/shader_bytecode_instruction_parser_core.sv
// Top level of the shader bytecode instruction parser core.
//
//   channel | direction | ports                 | moves
//   --------+-----------+-----------------------+--------------------------------
//   req     | in        | req_valid / req_ready | one section word (or a start)
//   rsp     | out       | rsp_valid / rsp_ready | one decoded instruction or error
//
// Rate: one word per clock sustained while results are taken. A word lands in
// the input register; the parser state machine consumes it once the output
// slot is free and loads any result into the output register.
// Reset: synchronous, active high; clears the parser to idle, empties both
// registers. Stalls: while a result waits in the output register, the input
// register still takes a word if it is empty; it then holds until the result
// is taken. Words that give no result still wait for a free output slot.
module shader_bytecode_instruction_parser_core
   import sbip_pkg::*;
#(
   parameter int MAX_SECTION_WORDS = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_word,
   input  logic        req_start_req,
   input  logic [15:0] req_words_following,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_operation,
   output logic        rsp_scalar_first,
   output logic [2:0]  rsp_comp_count,
   output logic        rsp_has_input,
   output logic [2:0]  rsp_input_table,
   output logic [31:0] rsp_input_offset,
   output logic [2:0]  rsp_output_table,
   output logic [31:0] rsp_output_offset,
   output logic        rsp_last_instruction
);

   logic    item_valid;
   req_type item;
   logic    advance;
   logic    res_valid;
   rsp_type res;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Advance the held word when the output slot is free or frees this cycle.
   assign advance = item_valid && (!rsp_valid_ff || rsp_ready);

   sbip_in_reg u_in_reg (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_word            (req_word),
      .req_start_req       (req_start_req),
      .req_words_following (req_words_following),
      .advance             (advance),
      .item_valid          (item_valid),
      .item                (item)
   );

   sbip_parser #(
      .MAX_SECTION_WORDS (MAX_SECTION_WORDS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output register: load a new result, drop the old one once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_error_code       = rsp_ff.error_code;
   assign rsp_operation        = rsp_ff.operation;
   assign rsp_scalar_first     = rsp_ff.scalar_first;
   assign rsp_comp_count       = rsp_ff.comp_count;
   assign rsp_has_input        = rsp_ff.has_input;
   assign rsp_input_table      = rsp_ff.input_table;
   assign rsp_input_offset     = rsp_ff.input_offset;
   assign rsp_output_table     = rsp_ff.output_table;
   assign rsp_output_offset    = rsp_ff.output_offset;
   assign rsp_last_instruction = rsp_ff.last_instruction;

endmodule

FILE: hw/rtl/sbip_checker.sv
// Port-level checker of the parser core and its bind to the top level.
module sbip_checker
   import sbip_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_error_code,
   input logic        rsp_operation,
   input logic        rsp_scalar_first,
   input logic [2:0]  rsp_comp_count,
   input logic        rsp_has_input,
   input logic [2:0]  rsp_input_table,
   input logic [31:0] rsp_input_offset,
   input logic [2:0]  rsp_output_table,
   input logic [31:0] rsp_output_offset,
   input logic        rsp_last_instruction
);

   localparam logic [2:0] ErrOk = ERR_OK;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_code)
         && $stable(rsp_output_offset) && $stable(rsp_input_offset))
      else $error("stalled transaction changed");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ErrOk |-> !rsp_operation && !rsp_scalar_first
         && rsp_comp_count == 3'd0 && !rsp_has_input
         && rsp_input_table == 3'd0 && rsp_output_table == 3'd0
         && rsp_input_offset == 32'd0 && rsp_output_offset == 32'd0
         && !rsp_last_instruction)
      else $error("error transaction carries fields");

   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ErrOk |-> rsp_comp_count != 3'd0
         && rsp_comp_count <= 3'd4 && rsp_has_input == rsp_operation)
      else $error("bad component count or input flag");

   a_nop_no_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == ErrOk && !rsp_has_input
         |-> rsp_input_table == 3'd0 && rsp_input_offset == 32'd0)
      else $error("nop carries input operand");

endmodule

bind shader_bytecode_instruction_parser_core sbip_checker u_sbip_checker (.*);
